FILE: rtl/core/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// shared types and codes for the pointer gesture recogniser
// ----------------------------------------------------------------------------
`default_nettype none

package pgr_pkg;

    typedef enum logic [1:0] {
        FUNC_DOWN = 2'd0,
        FUNC_UP   = 2'd1,
        FUNC_MOVE = 2'd2,
        FUNC_TICK = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        GEST_CLICK      = 3'd0,
        GEST_DRAG_START = 3'd1,
        GEST_DRAG       = 3'd2,
        GEST_DRAG_STOP  = 3'd3,
        GEST_HOLD       = 3'd4
    } gesture_t;

    localparam logic CFG_DRAG_THRESHOLD = 1'b0;
    localparam logic CFG_HOLD_TICKS     = 1'b1;

    localparam int unsigned THRESH_BITS = 8;
    localparam int unsigned TICK_BITS   = 16;
    localparam int unsigned CFG_BITS    = 16;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd10;
    localparam logic [TICK_BITS-1:0]   HOLD_RESET   = 16'd500;

endpackage

`default_nettype wire

FILE: rtl/core/pointer_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// pointer_gesture_recognizer
// turns pointer down, up, move and tick requests into gesture events
// ----------------------------------------------------------------------------
//  channel   direction  tdata                          tuser
//  s_*       in         pos_x, pos_y                   func
//  m_*       out        event_x, event_y, origin x, y  gesture
//  cfg_*     in         index 0 drag_threshold, 1 hold_ticks (cfg_data)
//
//  one request per cycle sustained while no stalled result holds the input
//  register; a result reaches m_* via the input register, then the result register
//  reset clears the press, drag and hold state and loads register defaults
//  a stalled result holds the result register; the input register then
//  holds only if its request would produce a result
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_gesture_recognizer
    import pgr_pkg::*;
#(
    parameter  int unsigned COORD_BITS = 16,
    localparam int unsigned IN_BYTES   = (2 * COORD_BITS + 7) / 8,
    localparam int unsigned OUT_BYTES  = (4 * COORD_BITS + 7) / 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [IN_BYTES*8-1:0]      s_tdata,   // pos_x, pos_y
    input  wire logic [1:0]                 s_tuser,   // func

    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [OUT_BYTES*8-1:0]          m_tdata,   // event_x, event_y, origin_x, origin_y
    output logic [2:0]                      m_tuser,   // gesture

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [CFG_BITS-1:0]        cfg_data
);

    localparam int unsigned SQ_BITS   = 2 * COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // configuration
    logic [THRESH_BITS-1:0] thresh_reg;
    logic [TICK_BITS-1:0]   hold_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= THRESH_RESET;
            hold_ticks_reg <= HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_DRAG_THRESHOLD)
                thresh_reg <= cfg_data[THRESH_BITS-1:0];
            else
                hold_ticks_reg <= cfg_data[TICK_BITS-1:0];
        end
    end

    // input register
    logic   in_valid_reg;
    func_t  in_func_reg;
    coord_t in_x_reg;
    coord_t in_y_reg;
    logic   advance;

    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= func_t'(s_tuser);
            in_x_reg    <= s_tdata[COORD_BITS-1:0];
            in_y_reg    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // gesture state
    logic                 press_active_reg, press_active_next;
    logic                 drag_active_reg,  drag_active_next;
    logic                 hold_armed_reg,   hold_armed_next;
    logic [TICK_BITS-1:0] hold_count_reg,   hold_count_next;
    coord_t               press_x_reg,      press_x_next;
    coord_t               press_y_reg,      press_y_next;

    // distance test
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;
    logic [2*COORD_BITS-1:0]      sq_x;
    logic [2*COORD_BITS-1:0]      sq_y;
    logic [SQ_BITS-1:0]           dist_sq;
    logic [2*THRESH_BITS-1:0]     thresh_sq;
    logic                         reach;
    logic [TICK_BITS-1:0]         count_inc;

    assign dx = {in_x_reg[COORD_BITS-1], in_x_reg} - {press_x_reg[COORD_BITS-1], press_x_reg};
    assign dy = {in_y_reg[COORD_BITS-1], in_y_reg} - {press_y_reg[COORD_BITS-1], press_y_reg};

    always_comb
    begin
        logic [COORD_BITS:0] nx;
        logic [COORD_BITS:0] ny;
        nx = -dx;
        ny = -dy;
        ax = dx[COORD_BITS] ? nx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay = dy[COORD_BITS] ? ny[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    end

    assign sq_x      = ax * ax;
    assign sq_y      = ay * ay;
    assign dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
    assign thresh_sq = thresh_reg * thresh_reg;
    assign reach     = dist_sq >= SQ_BITS'(thresh_sq);
    assign count_inc = hold_count_reg + 1'b1;

    // per-request decision
    logic     has_result;
    gesture_t res_gesture;
    coord_t   res_x;
    coord_t   res_y;

    always_comb
    begin
        press_active_next = press_active_reg;
        drag_active_next  = drag_active_reg;
        hold_armed_next   = hold_armed_reg;
        hold_count_next   = hold_count_reg;
        press_x_next      = press_x_reg;
        press_y_next      = press_y_reg;
        has_result        = 1'b0;
        res_gesture       = GEST_CLICK;
        res_x             = in_x_reg;
        res_y             = in_y_reg;

        unique case (in_func_reg)
            FUNC_DOWN:
            begin
                press_x_next      = in_x_reg;
                press_y_next      = in_y_reg;
                press_active_next = 1'b1;
                drag_active_next  = 1'b0;
                hold_armed_next   = 1'b1;
                hold_count_next   = '0;
            end
            FUNC_UP:
            begin
                if (press_active_reg)
                begin
                    has_result        = 1'b1;
                    res_gesture       = drag_active_reg ? GEST_DRAG_STOP : GEST_CLICK;
                    press_active_next = 1'b0;
                    drag_active_next  = 1'b0;
                    hold_armed_next   = 1'b0;
                end
            end
            FUNC_MOVE:
            begin
                if (press_active_reg)
                begin
                    if (drag_active_reg)
                    begin
                        has_result  = 1'b1;
                        res_gesture = GEST_DRAG;
                    end
                    else if (reach)
                    begin
                        has_result       = 1'b1;
                        res_gesture      = GEST_DRAG_START;
                        drag_active_next = 1'b1;
                        hold_armed_next  = 1'b0;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (hold_armed_reg)
                begin
                    hold_count_next = count_inc;
                    if (count_inc >= hold_ticks_reg || count_inc == '0)
                    begin
                        has_result      = 1'b1;
                        res_gesture     = GEST_HOLD;
                        res_x           = press_x_reg;
                        res_y           = press_y_reg;
                        hold_armed_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register
    logic     m_valid_reg;
    gesture_t m_gesture_reg;
    coord_t   m_event_x_reg;
    coord_t   m_event_y_reg;
    coord_t   m_origin_x_reg;
    coord_t   m_origin_y_reg;

    assign advance = in_valid_reg && (!has_result || !m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_active_reg <= 1'b0;
            drag_active_reg  <= 1'b0;
            hold_armed_reg   <= 1'b0;
            hold_count_reg   <= '0;
            press_x_reg      <= '0;
            press_y_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                press_active_reg <= press_active_next;
                drag_active_reg  <= drag_active_next;
                hold_armed_reg   <= hold_armed_next;
                hold_count_reg   <= hold_count_next;
                press_x_reg      <= press_x_next;
                press_y_reg      <= press_y_next;
            end
            if (advance && has_result)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            m_gesture_reg  <= res_gesture;
            m_event_x_reg  <= res_x;
            m_event_y_reg  <= res_y;
            m_origin_x_reg <= press_x_reg;
            m_origin_y_reg <= press_y_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_gesture_reg;
    assign m_tdata  = (OUT_BYTES*8)'({m_origin_y_reg, m_origin_x_reg,
                                      m_event_y_reg, m_event_x_reg});

endmodule

`default_nettype wire
